/* rtl/core/kbs_pkg.sv */
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types and constants of the Keltner channel breakout block: the back
// end state type, the signal codes and the configuration register map.
// ----------------------------------------------------------------------------
package kbs_pkg;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_TAIL,
    BK_SCALE,
    BK_DONE
  } back_state_t;

  // Breakout direction codes, two-bit two's complement.
  localparam logic [1:0] SIG_ZERO = 2'b00;
  localparam logic [1:0] SIG_POS  = 2'b01;
  localparam logic [1:0] SIG_NEG  = 2'b11;

  // Configuration register map.
  localparam int               CFG_ADDR_BITS   = 2;
  localparam int               CFG_DATA_BITS   = 32;
  localparam logic [1:0]       REG_BAND_MULT   = 2'd0;
  localparam int               BAND_MULT_BITS  = 12;
  localparam logic [11:0]      BAND_MULT_RESET = 12'd512;

  // Precision at which the EMA tap weights are built before rounding.
  localparam int               WEIGHT_PREC     = 56;

  // Result stream width: the signal sits in the low two bits.
  localparam int               OUT_TDATA_BITS  = 8;

endpackage

/* rtl/core/keltner_breakout_signal.sv */
// ----------------------------------------------------------------------------
// keltner_breakout_signal
// Keltner channel breakout detector: one result per price bar.
// ----------------------------------------------------------------------------
// Bars (high, low, close) are taken one per cycle into a QUEUE_DEPTH entry
// queue while it has room. For each bar that can give a signal the evaluation
// stage walks the WINDOW+1 EMA taps through the single price-by-weight
// multiplier, then finishes the sum, scales the band and compares into the
// output register, waiting there while the output is stalled. Bars in warm-up,
// or with a zero range sum, skip the filter. One bar is evaluated at a time:
// the next leaves the queue only as the result of the last one is registered.
// The signal stays 0 with warmed_up low until WINDOW+1 bars have been seen.
// ----------------------------------------------------------------------------
module keltner_breakout_signal #(
  parameter int  WINDOW           = 20,
  parameter int  PRICE_BITS       = 32,
  parameter int  WEIGHT_FRAC_BITS = 24,
  parameter int  QUEUE_DEPTH      = 4,
  localparam int IN_TDATA_BITS    = ((3 * PRICE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Bar input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: high_price, low_price, close_price (PRICE_BITS each).
  input  logic [IN_TDATA_BITS-1:0]            in_tdata,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: signal (2 bits, signed), zero fill.
  output logic [kbs_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  // Fields from bit 0: warmed_up.
  output logic                                out_tuser,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [kbs_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [kbs_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [kbs_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);

  import kbs_pkg::*;

  localparam int RSW = PRICE_BITS + $clog2(WINDOW);
  localparam int EW  = 1 + RSW + PRICE_BITS;

  logic [BAND_MULT_BITS-1:0] band_mult_r;
  logic                      push_valid, push_ready;
  logic [EW-1:0]             push_data;
  logic                      q_valid, q_ready;
  logic [EW-1:0]             q_data;
  logic [1:0]                signal;
  logic                      cfg_write;

  // Configuration registers: writes complete in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_BAND_MULT) ? CFG_DATA_BITS'(band_mult_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_mult_r <= BAND_MULT_RESET;
    end else if (cfg_write && (cfg_paddr == REG_BAND_MULT)) begin
      band_mult_r <= cfg_pwdata[BAND_MULT_BITS-1:0];
    end
  end

  // Intake and window bookkeeping.
  kbs_front #(
    .WINDOW     (WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .high_price  (in_tdata[0 +: PRICE_BITS]),
    .low_price   (in_tdata[PRICE_BITS +: PRICE_BITS]),
    .close_price (in_tdata[2*PRICE_BITS +: PRICE_BITS]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Decoupling queue.
  kbs_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Centre line, band and comparison.
  kbs_back #(
    .WINDOW           (WINDOW),
    .PRICE_BITS       (PRICE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .band_mult  (band_mult_r),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_signal (signal),
    .out_warm   (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_BITS - 2){1'b0}}, signal};

  // A bar still in warm-up never reports a breakout.
  a_cold_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[1:0] == SIG_ZERO))
    else $error("breakout reported before warm-up");

  // The evaluation stage only takes entries that are there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> q_valid)
    else $error("evaluation stage popped an empty queue");

  // Intake stalls only when the queue holds work.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("intake stalled with an empty queue");

endmodule

/* rtl/core/kbs_queue.sv */
// ----------------------------------------------------------------------------
// kbs_queue
// Short first-in first-out queue that decouples the bar intake from the
// signal evaluation. Entries are opaque words.
// ----------------------------------------------------------------------------
module kbs_queue #(
  parameter int WIDTH = 70,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/kbs_front.sv */
// ----------------------------------------------------------------------------
// kbs_front
// Bar intake: computes each bar's true range against the previous close,
// keeps the range window and its running sum, tracks warm-up, and queues
// {warm flag, range sum, close} for the evaluation stage.
// ----------------------------------------------------------------------------
module kbs_front #(
  parameter int WINDOW     = 20,
  parameter int PRICE_BITS = 32,
  localparam int RSW       = PRICE_BITS + $clog2(WINDOW),
  localparam int EW        = 1 + RSW + PRICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] high_price,
  input  logic [PRICE_BITS-1:0] low_price,
  input  logic [PRICE_BITS-1:0] close_price,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [EW-1:0]         push_data
);

  localparam int BW = $clog2(WINDOW + 2);

  logic [PRICE_BITS-1:0] prev_close_r;
  logic [PRICE_BITS-1:0] range_hist_r [WINDOW];
  logic [RSW-1:0]        range_sum_r, range_sum_nxt;
  logic [BW-1:0]         bars_seen_r;
  logic                  warm;
  logic                  take;
  logic [PRICE_BITS-1:0] span, d_high, d_low, t_range;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;
  assign warm       = (bars_seen_r >= BW'(WINDOW + 1));

  // True range: the largest of the bar span and the gaps to the previous close.
  always_comb begin
    span    = (high_price > low_price) ? high_price - low_price : '0;
    d_high  = (high_price >= prev_close_r) ? high_price - prev_close_r
                                           : prev_close_r - high_price;
    d_low   = (low_price >= prev_close_r) ? low_price - prev_close_r
                                          : prev_close_r - low_price;
    t_range = span;
    if (d_high > t_range) begin
      t_range = d_high;
    end
    if (d_low > t_range) begin
      t_range = d_low;
    end
    range_sum_nxt = range_sum_r - RSW'(range_hist_r[WINDOW-1]) + RSW'(t_range);
  end

  assign push_data = {warm, range_sum_nxt, close_price};

  // Window state: the oldest range drops out of the sum as the new one enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_close_r <= '0;
      range_sum_r  <= '0;
      bars_seen_r  <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        range_hist_r[i] <= '0;
      end
    end else if (take) begin
      prev_close_r    <= close_price;
      range_sum_r     <= range_sum_nxt;
      range_hist_r[0] <= t_range;
      for (int i = 1; i < WINDOW; i++) begin
        range_hist_r[i] <= range_hist_r[i-1];
      end
      if (!warm) begin
        bars_seen_r <= bars_seen_r + BW'(1);
      end
    end
  end

endmodule

/* rtl/core/kbs_back.sv */
// ----------------------------------------------------------------------------
// kbs_back
// Signal evaluation: runs the EMA centre line as a WINDOW+1 tap FIR through
// one shared multiplier, scales the band, compares and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module kbs_back #(
  parameter int WINDOW           = 20,
  parameter int PRICE_BITS       = 32,
  parameter int WEIGHT_FRAC_BITS = 24,
  localparam int RSW             = PRICE_BITS + $clog2(WINDOW),
  localparam int EW              = 1 + RSW + PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [kbs_pkg::BAND_MULT_BITS-1:0] band_mult,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  logic [EW-1:0]                      pop_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_signal,
  output logic                               out_warm
);

  import kbs_pkg::*;

  localparam int WB  = WEIGHT_FRAC_BITS;
  localparam int KW  = $clog2(WINDOW + 1);
  localparam int HW  = $clog2(WINDOW);
  localparam int PW  = PRICE_BITS + WB;
  localparam int AW  = PW + $clog2(WINDOW + 2);
  localparam int BPW = RSW + BAND_MULT_BITS;
  localparam int XW  = PRICE_BITS + WB + $clog2(WINDOW + 1) + $clog2(WINDOW + 2) + 14;

  // Tap weights, newest close first, oldest (seed) close last.
  function automatic logic [(WINDOW+1)*WB-1:0] build_weights();
    logic [127:0]              q;
    logic [127:0]              w;
    logic [(WINDOW+1)*WB-1:0]  tab;
    q   = 128'd1 << WEIGHT_PREC;
    tab = '0;
    for (int k = 0; k <= WINDOW; k++) begin
      if (k < WINDOW) begin
        w = (q * 128'd2) / (WINDOW + 1);
      end else begin
        w = q;
      end
      w = (w + (128'd1 << (WEIGHT_PREC - WB - 1))) >> (WEIGHT_PREC - WB);
      tab[k*WB +: WB] = w[WB-1:0];
      q = (q * (WINDOW - 1)) / (WINDOW + 1);
    end
    return tab;
  endfunction

  localparam logic [(WINDOW+1)*WB-1:0] WEIGHTS = build_weights();

  back_state_t           state_r, state_nxt;
  logic [PRICE_BITS-1:0] hist_r [WINDOW];
  logic [PRICE_BITS-1:0] close_r, close_nxt;
  logic [RSW-1:0]        rs_r, rs_nxt;
  logic                  warm_r, warm_nxt;
  logic                  run_r, run_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic                  pv_r, pv_nxt;
  logic [AW-1:0]         acc_r, acc_nxt;
  logic [XW-1:0]         l_r, l_nxt, c_r, c_nxt, b_r, b_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            sig_r, sig_nxt;
  logic                  owarm_r, owarm_nxt;
  logic                  shift, load;
  logic [KW-1:0]         hidx_full;
  logic [HW-1:0]         hidx;
  logic [PRICE_BITS-1:0] tap;
  logic [WB-1:0]         weight;
  logic [BPW-1:0]        bprod;
  logic                  above, below;

  assign out_valid  = out_valid_r;
  assign out_signal = sig_r;
  assign out_warm   = owarm_r;

  // Tap selection: age zero is the bar itself, older ages come from history.
  assign hidx_full = k_r - KW'(1);
  assign hidx      = hidx_full[HW-1:0];
  assign tap       = (k_r == '0) ? close_r : hist_r[hidx];
  assign weight    = WEIGHTS[int'(k_r)*WB +: WB];
  assign bprod     = BPW'(rs_r) * BPW'(band_mult);

  // Band comparison on the scaled terms.
  assign above = l_r > (c_r + b_r);
  assign below = c_r > (l_r + b_r);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    close_nxt     = close_r;
    rs_nxt        = rs_r;
    warm_nxt      = warm_r;
    run_nxt       = run_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    pv_nxt        = pv_r;
    acc_nxt       = acc_r;
    l_nxt         = l_r;
    c_nxt         = c_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sig_nxt       = sig_r;
    owarm_nxt     = owarm_r;
    shift         = 1'b0;
    load          = 1'b0;
    pop_ready     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        load = 1'b1;
      end
      BK_MAC: begin
        prod_nxt = tap * weight;
        pv_nxt   = 1'b1;
        if (pv_r) begin
          acc_nxt = acc_r + AW'(prod_r);
        end
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(WINDOW)) begin
          state_nxt = BK_TAIL;
        end
      end
      BK_TAIL: begin
        acc_nxt   = acc_r + AW'(prod_r);
        pv_nxt    = 1'b0;
        state_nxt = BK_SCALE;
      end
      BK_SCALE: begin
        l_nxt     = (XW'(close_r) * XW'(WINDOW)) << (WB + 8);
        c_nxt     = (XW'(acc_r) * XW'(WINDOW)) << 8;
        b_nxt     = XW'(bprod) << WB;
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          owarm_nxt     = warm_r;
          if (run_r && above) begin
            sig_nxt = SIG_POS;
          end else if (run_r && below) begin
            sig_nxt = SIG_NEG;
          end else begin
            sig_nxt = SIG_ZERO;
          end
          shift     = 1'b1;
          state_nxt = BK_IDLE;
          load      = 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Take the next queued bar; skip the filter when no signal can result.
    if (load && pop_valid) begin
      pop_ready = 1'b1;
      close_nxt = pop_data[PRICE_BITS-1:0];
      rs_nxt    = pop_data[PRICE_BITS +: RSW];
      warm_nxt  = pop_data[EW-1];
      run_nxt   = pop_data[EW-1] && (pop_data[PRICE_BITS +: RSW] != '0);
      k_nxt     = '0;
      acc_nxt   = '0;
      pv_nxt    = 1'b0;
      state_nxt = run_nxt ? BK_MAC : BK_DONE;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    close_r <= close_nxt;
    rs_r    <= rs_nxt;
    warm_r  <= warm_nxt;
    run_r   <= run_nxt;
    k_r     <= k_nxt;
    prod_r  <= prod_nxt;
    pv_r    <= pv_nxt;
    acc_r   <= acc_nxt;
    l_r     <= l_nxt;
    c_r     <= c_nxt;
    b_r     <= b_nxt;
    sig_r   <= sig_nxt;
    owarm_r <= owarm_nxt;
  end

  // Close history, newest first, advanced once per finished bar.
  always_ff @(posedge clk) begin
    if (shift) begin
      hist_r[0] <= close_r;
      for (int i = 1; i < WINDOW; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

endmodule

/* tb/sv/tb_keltner_breakout_signal.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keltner_breakout_signal
// Self-checking bench for the Keltner channel breakout detector. Price bars
// are streamed in while both stream sides idle at random. A bit-exact
// predictor computes the true range, the FIR form of the EMA centre line and
// the band test for every bar. The band multiplier is rewritten between
// phases and read back.
// ----------------------------------------------------------------------------
module tb_keltner_breakout_signal;
  import kbs_pkg::*;

  localparam int WIN            = 20;
  localparam int PRICE_W        = 32;
  localparam int FRAC_W         = 24;
  localparam int BAR_W          = 3 * PRICE_W;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 120;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int RANDOM_PHASES  = 6;
  localparam int BARS_PER_PHASE = 188;
  localparam int MAX_REPORTS    = 40;
  localparam longint MAX_PX     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (WEIGHT_PREC - FRAC_W - 1);
  localparam logic [CFG_ADDR_BITS-1:0] BAND_MULT_ADDR = CFG_ADDR_BITS'(4 * REG_BAND_MULT);

  // Expected outcome of one bar.
  typedef struct packed {
    logic [1:0] sig;
    logic       warm;
  } verdict_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  // Fields from bit 0: high_price, low_price, close_price.
  logic [BAR_W-1:0]           in_tdata    = '0;
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  // Fields from bit 0: signal (2 bits, signed), zero fill.
  logic [OUT_TDATA_BITS-1:0]  out_tdata;
  // Fields from bit 0: warmed_up.
  logic                       out_tuser;
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   cfg_paddr   = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_pwdata  = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_prdata;
  logic                       cfg_pready;

  // Predictor state.
  logic [63:0]                tap_w [0:WIN];
  logic [63:0]                close_hist [0:WIN-1];
  logic [63:0]                range_hist [0:WIN-1];
  logic [63:0]                range_sum  = '0;
  int unsigned                bars_seen  = 0;
  logic [BAND_MULT_BITS-1:0]  band_mult  = BAND_MULT_RESET;

  logic [BAR_W-1:0]           bar_q [$];
  verdict_t                   verdict_q [$];

  int   err_count       = 0;
  int   cycle_count     = 0;
  int   sender_idle_pct = 0;
  int   recv_idle_pct   = 0;
  int   hold_req        = 0;
  int   hold_seen       = 0;
  int   hold_left       = 0;
  logic bar_taken       = 1'b0;

  keltner_breakout_signal #(
    .WINDOW           (WIN),
    .PRICE_BITS       (PRICE_W),
    .WEIGHT_FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s, got %0h expected %0h",
               cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // Work out the verdict for one accepted bar and advance the history.
  function automatic void predict_breakout(input logic [BAR_W-1:0] bar);
    logic [63:0]  hi, lo, cl, prev, tr, d_hi, d_lo;
    logic [127:0] centre, lvl, ctr, band;
    verdict_t     v;
    int           k;
    hi   = 64'(bar[PRICE_W-1:0]);
    lo   = 64'(bar[2*PRICE_W-1:PRICE_W]);
    cl   = 64'(bar[3*PRICE_W-1:2*PRICE_W]);
    prev = close_hist[0];

    // True range over the previous close; high below low gives no span.
    tr   = (hi > lo) ? hi - lo : 64'd0;
    d_hi = (hi >= prev) ? hi - prev : prev - hi;
    d_lo = (lo >= prev) ? lo - prev : prev - lo;
    if (d_hi > tr) tr = d_hi;
    if (d_lo > tr) tr = d_lo;
    range_sum = range_sum - range_hist[WIN-1] + tr;
    for (k = WIN - 1; k > 0; k--) range_hist[k] = range_hist[k-1];
    range_hist[0] = tr;

    v.warm = (bars_seen >= WIN + 1);
    v.sig  = SIG_ZERO;
    if (v.warm && range_sum != 0) begin
      // Centre line as a weighted sum of the current and past closes.
      centre = 128'(tap_w[0]) * 128'(cl);
      for (k = 1; k < WIN; k++) centre += 128'(tap_w[k]) * 128'(close_hist[k-1]);
      centre += 128'(tap_w[WIN]) * 128'(close_hist[WIN-1]);
      // Compare with both sides scaled by the window and the Q4.8 multiplier.
      lvl  = (128'(cl) * 128'(256 * WIN)) << FRAC_W;
      ctr  = centre * 128'(256 * WIN);
      band = (128'(band_mult) * 128'(range_sum)) << FRAC_W;
      if (lvl > ctr + band) v.sig = SIG_POS;
      else if (ctr > lvl + band) v.sig = SIG_NEG;
    end

    for (k = WIN - 1; k > 0; k--) close_hist[k] = close_hist[k-1];
    close_hist[0] = cl;
    if (bars_seen < WIN + 1) bars_seen++;
    verdict_q.insert(verdict_q.size(), v);
  endfunction

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= BAND_MULT_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    if (write) band_mult = wdata[BAND_MULT_BITS-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Let every queued bar go in and every expected result come out.
  task automatic wait_all_done();
    int waited;
    waited = 0;
    while ((bar_q.size() != 0 || in_tvalid || verdict_q.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Bar driver: holds a bar until its transfer, then may idle before the next.
  always @(negedge clk) begin
    if (in_tvalid && !bar_taken) begin
      in_tvalid <= 1'b1;
    end else if (rst_n && bar_q.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata  <= bar_q.pop_front();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every bar transfer and checks every result transfer.
  always @(posedge clk) begin : check_results
    verdict_t want;
    cycle_count++;
    bar_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_breakout(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_tdata), 32'd0);
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata !== OUT_TDATA_BITS'(want.sig))
          report_mismatch("signal", 32'(out_tdata), 32'(want.sig));
        if (out_tuser !== want.warm)
          report_mismatch("warmed_up", 32'(out_tuser), 32'(want.warm));
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL keltner_breakout_signal");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0]      q;
    logic [31:0]      rd;
    logic [31:0]      mult_plan [0:RANDOM_PHASES-1];
    logic [BAR_W-1:0] bar;
    logic [2:0]       ext;
    longint           walk_px, spread, step, hi_px, lo_px;
    int               k, ph, n, r;

    // EMA taps at 56 fractional bits, rounded half up to the weight format.
    q = 64'd1 << WEIGHT_PREC;
    for (k = 0; k < WIN; k++) begin
      tap_w[k] = ((2 * q) / (WIN + 1) + ROUND_HALF) >> (WEIGHT_PREC - FRAC_W);
      q = q * (WIN - 1) / (WIN + 1);
    end
    tap_w[WIN] = (q + ROUND_HALF) >> (WEIGHT_PREC - FRAC_W);
    for (k = 0; k < WIN; k++) begin
      close_hist[k] = '0;
      range_hist[k] = '0;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the band multiplier.
    cfg_access(1'b0, '0, rd);
    if (rd !== 32'(BAND_MULT_RESET)) report_mismatch("band_multiplier reset", rd,
                                                     32'(BAND_MULT_RESET));

    // Directed bars: extremes, high below low, then a flat run that ends the
    // warm-up and finally leaves a window with zero range.
    sender_idle_pct = 38;
    recv_idle_pct   = 71;
    bar_q.insert(bar_q.size(), {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    bar_q.insert(bar_q.size(), {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    bar_q.insert(bar_q.size(), {32'h8000_0000, 32'h9ABC_DEF0, 32'h1234_5678});
    for (k = 0; k < 22; k++) bar_q.insert(bar_q.size(), {3{32'd1000}});
    wait_all_done();

    mult_plan[0] = 32'd0;
    mult_plan[1] = 32'd4095;
    mult_plan[2] = 32'hFFFF_F0C0;
    mult_plan[3] = $urandom;
    mult_plan[4] = 32'd1;
    mult_plan[5] = 32'h0000_0200;

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      sender_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 71 : 0;
      recv_idle_pct   = (ph < 2) ? 71 : (ph < 4) ? 38 : 0;

      // New band width, read back while the block is idle.
      cfg_access(1'b1, mult_plan[ph], rd);
      cfg_access(1'b0, '0, rd);
      if (rd !== 32'(band_mult)) report_mismatch("band_multiplier readback", rd,
                                                 32'(band_mult));

      // Receiver holds off while the whole phase is already on offer.
      if (ph == 0 || ph == 4) hold_req++;

      walk_px = (ph % 2 == 0) ? longint'($urandom_range(200, 20000)) : longint'($urandom);
      for (n = 0; n < BARS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // Noise: any bit pattern, high below low included.
          bar = {$urandom, $urandom, $urandom};
        end else if (r < 9) begin
          ext = 3'($urandom);
          bar = {{32{ext[2]}}, {32{ext[1]}}, {32{ext[0]}}};
        end else begin
          // Random walk with occasional jumps that break out of the band.
          spread = walk_px / 50 + 1;
          step   = longint'($urandom_range(0, 32'(2 * spread))) - spread;
          if ($urandom_range(0, 15) == 0) step = step * 12;
          walk_px = walk_px + step;
          if (walk_px < 0) walk_px = 0;
          if (walk_px > MAX_PX) walk_px = MAX_PX;
          hi_px = walk_px + longint'($urandom_range(0, 32'(spread)));
          lo_px = walk_px - longint'($urandom_range(0, 32'(spread)));
          if (hi_px > MAX_PX) hi_px = MAX_PX;
          if (lo_px < 0) lo_px = 0;
          bar = {32'(walk_px), 32'(lo_px), 32'(hi_px)};
        end
        if ($urandom_range(0, 99) == 0) walk_px = longint'($urandom);
        bar_q.insert(bar_q.size(), bar);
      end
      wait_all_done();
    end

    if (verdict_q.size() != 0)
      report_mismatch("results never delivered", 32'(verdict_q.size()), 32'd0);
    if (err_count == 0) begin
      $display("PASS keltner_breakout_signal");
    end else begin
      $display("FAIL keltner_breakout_signal");
    end
    $finish;
  end

endmodule
